// File: sv/aqz_pkg.sv
`timescale 1ns / 1ps
// aqz_pkg: shared types, constants and helpers of the absmax int8 quantiser
// used by every module of the block but aqz_ram; depends on nothing

package aqz_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int DEPTH_DEFAULT = 64;
    localparam int CNT_W         = 7;                 // holds a tensor length up to 64
    localparam int CODE_W        = 8;
    localparam int SCALE_BITS    = 7;                 // 127 = 2^7 - 1
    localparam int CODE_MAX      = (1 << SCALE_BITS) - 1;
    localparam int RECIP_W       = SAMPLE_WIDTH + SCALE_BITS;
    localparam int JOB_SLOTS     = 2;                 // one per buffer bank

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           final_req;
    } item_t;

    typedef struct packed {
        logic signed [CODE_W-1:0]  quantized;
        logic [SAMPLE_WIDTH-1:0]   max_abs;
        logic                      overflowed;
        logic                      end_of_run;
    } result_t;

    // one loaded tensor waiting for the back end
    typedef struct packed {
        logic [CNT_W-1:0]          count;
        logic [SAMPLE_WIDTH-1:0]   max_abs;
        logic                      overflowed;
        logic                      bank;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RECIP,
        BK_STREAM
    } bk_state_t;

    // magnitude of a two's complement sample, most negative value included
    function automatic logic [SAMPLE_WIDTH-1:0] sample_mag(input logic [SAMPLE_WIDTH-1:0] raw);
        logic [SAMPLE_WIDTH-1:0] mag;
        mag = raw[SAMPLE_WIDTH-1] ? (~raw + SAMPLE_WIDTH'(1)) : raw;
        return mag;
    endfunction

endpackage

// File: sv/aqz_ram.sv
`timescale 1ns / 1ps
// aqz_ram: generic single write port, single read port ram with registered read
// stand-alone, no package needed

module aqz_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/aqz_front.sv
`timescale 1ns / 1ps
// aqz_front: load side, writes samples into the current bank and tracks maxabs
// depends on aqz_pkg

module aqz_front
    import aqz_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  item_t                         item,
    output logic                          wr_en,
    output logic [$clog2(2*DEPTH)-1:0]    wr_addr,
    output logic [SAMPLE_WIDTH-1:0]       wr_data,
    output logic                          push,
    output job_t                          push_job
);

    localparam int AW = $clog2(2*DEPTH);

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SAMPLE_WIDTH-1:0] max_reg, max_next;
    logic                    drop_reg, drop_next;
    logic                    bank_reg, bank_next;

    logic [SAMPLE_WIDTH-1:0] mag;
    logic                    room;
    logic [CNT_W-1:0]        cnt_upd;
    logic [SAMPLE_WIDTH-1:0] max_upd;
    logic                    drop_upd;

    always_comb
    begin
        mag      = sample_mag(item.sample);
        room     = cnt_reg < CNT_W'(DEPTH);
        cnt_upd  = room ? (cnt_reg + CNT_W'(1)) : cnt_reg;
        max_upd  = (room && (mag > max_reg)) ? mag : max_reg;
        drop_upd = drop_reg | ~room;

        wr_en    = accept & room;
        wr_addr  = AW'(cnt_reg) + (bank_reg ? AW'(DEPTH) : AW'(0));
        wr_data  = item.sample;

        push     = accept & item.final_req;
        push_job = '{count: cnt_upd, max_abs: max_upd, overflowed: drop_upd, bank: bank_reg};

        cnt_next  = cnt_reg;
        max_next  = max_reg;
        drop_next = drop_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (item.final_req)
            begin
                // tensor closed, start the next one in the other bank
                cnt_next  = '0;
                max_next  = '0;
                drop_next = 1'b0;
                bank_next = ~bank_reg;
            end
            else
            begin
                cnt_next  = cnt_upd;
                max_next  = max_upd;
                drop_next = drop_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            max_reg  <= '0;
            drop_reg <= 1'b0;
            bank_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            max_reg  <= max_next;
            drop_reg <= drop_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// File: sv/aqz_job_fifo.sv
`timescale 1ns / 1ps
// aqz_job_fifo: two-entry queue of loaded tensors between front and back
// depends on aqz_pkg

module aqz_job_fifo
    import aqz_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    localparam int PTR_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int OCC_W = $clog2(JOB_SLOTS + 1);

    job_t             slot_reg [JOB_SLOTS];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0] occ_reg, occ_next;

    always_comb
    begin
        full        = occ_reg == OCC_W'(JOB_SLOTS);
        not_empty   = occ_reg != '0;
        head        = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(JOB_SLOTS - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(JOB_SLOTS - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

endmodule

// File: sv/aqz_back.sv
`timescale 1ns / 1ps
// aqz_back: per tensor reciprocal divider, then a read and quantise pipeline
// depends on aqz_pkg

module aqz_back
    import aqz_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  job_t                          job,
    output logic                          pop,
    output logic                          rd_en,
    output logic [$clog2(2*DEPTH)-1:0]    rd_addr,
    input  logic [SAMPLE_WIDTH-1:0]       rd_data,
    output logic                          result_strobe,
    output result_t                       result
);

    localparam int AW     = $clog2(2*DEPTH);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DCNT_W = $clog2(RECIP_W);
    localparam int PROD_W = SAMPLE_WIDTH + RECIP_W;
    localparam int CHK_W  = SAMPLE_WIDTH + CODE_W;

    bk_state_t               state_reg, state_next;
    job_t                    job_reg, job_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [SAMPLE_WIDTH-1:0] rem_reg, rem_next;
    logic [RECIP_W-1:0]      quo_reg, quo_next;
    logic [DCNT_W-1:0]       dcnt_reg, dcnt_next;
    logic [RECIP_W-1:0]      recip_reg, recip_next;
    logic [SAMPLE_WIDTH-1:0] smax_reg, smax_next;
    logic                    sdrop_reg, sdrop_next;

    logic                    div_bit;
    logic [SAMPLE_WIDTH:0]   rem_shift;
    logic [SAMPLE_WIDTH:0]   rem_sub;
    logic                    take;
    logic                    last_rd;

    // pipeline
    logic                    v0_reg, l0_reg;
    logic                    va_reg, la_reg, neg_a_reg;
    logic [SAMPLE_WIDTH-1:0] mag_a_reg;
    logic                    vb_reg, lb_reg, neg_b_reg;
    logic [PROD_W-1:0]       prod_b_reg;
    logic [RECIP_W-1:0]      n127_b_reg;
    logic                    vc_reg, lc_reg, neg_c_reg;
    logic [CODE_W-1:0]       qest_c_reg;
    logic [CHK_W-1:0]        qm_c_reg;
    logic [RECIP_W-1:0]      n127_c_reg;
    logic                    strobe_reg;
    result_t                 result_reg;

    logic [CODE_W-1:0]       qest_b;
    logic [CHK_W-1:0]        rem_d;
    logic [CODE_W-1:0]       q_d;
    logic [CODE_W-1:0]       code_d;

    // restoring division of 127 * 2^W by maxabs, one quotient bit per cycle
    always_comb
    begin
        div_bit   = dcnt_reg < DCNT_W'(SCALE_BITS);
        rem_shift = {rem_reg, div_bit};
        rem_sub   = rem_shift - {1'b0, job_reg.max_abs};
        take      = rem_shift >= {1'b0, job_reg.max_abs};
        last_rd   = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == job_reg.count;
        rd_addr   = AW'(rd_idx_reg) + (job_reg.bank ? AW'(DEPTH) : AW'(0));
    end

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        rd_idx_next = rd_idx_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dcnt_next   = dcnt_reg;
        recip_next  = recip_reg;
        smax_next   = smax_reg;
        sdrop_next  = sdrop_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_next   = job;
                    rem_next   = '0;
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = BK_RECIP;
                end
            end
            BK_RECIP:
            begin
                rem_next  = take ? rem_sub[SAMPLE_WIDTH-1:0] : rem_shift[SAMPLE_WIDTH-1:0];
                quo_next  = {quo_reg[RECIP_W-2:0], take};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(RECIP_W - 1))
                begin
                    recip_next  = {quo_reg[RECIP_W-2:0], take};
                    smax_next   = job_reg.max_abs;
                    sdrop_next  = job_reg.overflowed;
                    rd_idx_next = '0;
                    state_next  = BK_STREAM;
                end
            end
            BK_STREAM:
            begin
                rd_en       = 1'b1;
                rd_idx_next = rd_idx_reg + IDX_W'(1);
                if (last_rd)
                begin
                    // bank is free once its last entry has been read
                    pop        = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // final stage: estimate is exact or one short, fix with a remainder check
    always_comb
    begin
        qest_b = prod_b_reg[SAMPLE_WIDTH + SCALE_BITS:SAMPLE_WIDTH];
        rem_d  = CHK_W'(n127_c_reg) - qm_c_reg;
        q_d    = qest_c_reg + ((rem_d >= CHK_W'(smax_reg)) ? CODE_W'(1) : CODE_W'(0));
        if (q_d > CODE_W'(CODE_MAX))
        begin
            q_d = CODE_W'(CODE_MAX);
        end
        code_d = neg_c_reg ? (~q_d + CODE_W'(1)) : q_d;
        if (smax_reg == '0)
        begin
            code_d = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            v0_reg     <= 1'b0;
            l0_reg     <= 1'b0;
            va_reg     <= 1'b0;
            la_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            lb_reg     <= 1'b0;
            vc_reg     <= 1'b0;
            lc_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            v0_reg     <= rd_en;
            l0_reg     <= rd_en & last_rd;
            va_reg     <= v0_reg;
            la_reg     <= l0_reg;
            vb_reg     <= va_reg;
            lb_reg     <= la_reg;
            vc_reg     <= vb_reg;
            lc_reg     <= lb_reg;
            strobe_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        rd_idx_reg <= rd_idx_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dcnt_reg   <= dcnt_next;
        recip_reg  <= recip_next;
        smax_reg   <= smax_next;
        sdrop_reg  <= sdrop_next;

        mag_a_reg  <= sample_mag(rd_data);
        neg_a_reg  <= rd_data[SAMPLE_WIDTH-1];

        prod_b_reg <= PROD_W'(mag_a_reg) * PROD_W'(recip_reg);
        n127_b_reg <= (RECIP_W'(mag_a_reg) << SCALE_BITS) - RECIP_W'(mag_a_reg);
        neg_b_reg  <= neg_a_reg;

        qest_c_reg <= qest_b;
        qm_c_reg   <= CHK_W'(qest_b) * CHK_W'(smax_reg);
        n127_c_reg <= n127_b_reg;
        neg_c_reg  <= neg_b_reg;

        result_reg <= '{quantized: code_d, max_abs: smax_reg,
                        overflowed: sdrop_reg, end_of_run: lc_reg};
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

// File: sv/absmax_int8_quantizer_core.sv
`timescale 1ns / 1ps
// absmax_int8_quantizer_core: top level of the symmetric absmax int8 quantiser
// depends on aqz_pkg, aqz_front, aqz_job_fifo, aqz_ram, aqz_back

// A tensor is loaded one sample per word (start high while busy is low), at one word
// per cycle; the word with final_req set closes it. The buffer ram has two banks, so
// the next tensor can be loaded while the previous one is being emitted; busy rises
// once a second tensor is closed while the back end still holds the first, and falls
// when the last sample of that first tensor has been read from the ram. The back end
// takes a tensor when idle, a bit-serial divider forms floor(127 * 2^24 / maxabs),
// and then the codes come out one per cycle in load order, each ram read passing
// through the read, magnitude, multiply, check multiply and correction registers.
// Each code sits on result for exactly one cycle with result_strobe high; there is no way to
// hold it off, so the receiver must take every word as it comes. end_of_run
// marks the last code of a tensor, overflowed reports samples dropped past DEPTH,
// and max_abs gives the scale as max_abs / 127.

module absmax_int8_quantizer_core
    import aqz_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    result_strobe,
    output result_t result
);

    localparam int AW = $clog2(2*DEPTH);

    logic                    accept;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [SAMPLE_WIDTH-1:0] wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [SAMPLE_WIDTH-1:0] rd_data;
    logic                    job_push;
    job_t                    push_job;
    logic                    job_pop;
    logic                    job_full;
    logic                    job_valid;
    job_t                    job_head;

    // both banks taken: hold off the loader
    assign busy   = job_full;
    assign accept = start & ~busy;

    aqz_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .push     (job_push),
        .push_job (push_job)
    );

    aqz_job_fifo u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .pop       (job_pop),
        .full      (job_full),
        .not_empty (job_valid),
        .head      (job_head)
    );

    // two banks of DEPTH samples
    aqz_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (2*DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    aqz_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job           (job_head),
        .pop           (job_pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

`ifndef SYNTHESIS
    // a burst runs without gaps until its end_of_run word
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.end_of_run |=> result_strobe)
        else $error("gap inside a code burst");

    // a zero scale gives zero codes
    a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.max_abs == '0) |-> result.quantized == '0)
        else $error("non-zero code with zero max_abs");

    // codes stay symmetric, -128 never appears
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> result.quantized != {1'b1, {(CODE_W-1){1'b0}}})
        else $error("code outside symmetric range");
`endif

endmodule

// File: sim/absmax_int8_quantizer_core_tb.sv
`timescale 1ns / 1ps
// absmax_int8_quantizer_core_tb: self-checking bench for the absmax int8 quantiser
// depends on aqz_pkg and absmax_int8_quantizer_core; a scoreboard class predicts the codes

module absmax_int8_quantizer_core_tb;
    import aqz_pkg::*;

    localparam int PERIOD      = 8;
    localparam int WORD_GOAL   = 430;
    localparam int CALM_TAIL   = 60;        // last words go in with no gaps
    localparam int SETTLE      = 80;        // divider plus pipeline, with margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 50;

    // predicts the burst of codes that each closed tensor produces
    class code_scoreboard;
        logic signed [SAMPLE_WIDTH-1:0] held_samples [DEPTH_DEFAULT];
        int unsigned                    held_count;
        longint unsigned                peak_mag;
        bit                             dropped;
        result_t                        codes_due [$];
        int unsigned                    errors;

        function new();
            held_count = 0;
            peak_mag   = 0;
            dropped    = 1'b0;
            errors     = 0;
        endfunction

        function longint unsigned mag_of(logic signed [SAMPLE_WIDTH-1:0] s);
            longint wide;
            wide = longint'(s);
            return (wide < 0) ? longint'(-wide) : wide;
        endfunction

        // truncation toward zero, clamped to the int8 code range
        function logic signed [CODE_W-1:0] code_of(logic signed [SAMPLE_WIDTH-1:0] s);
            longint unsigned q;
            logic signed [CODE_W-1:0] c;
            if (peak_mag == 0)
                return '0;
            q = (longint'(CODE_MAX) * mag_of(s)) / peak_mag;
            if (q > CODE_MAX)
                q = CODE_MAX;
            c = CODE_W'(q);
            return (s < 0) ? -c : c;
        endfunction

        function int unsigned pending();
            return codes_due.size();
        endfunction

        task take_word(item_t w);
            longint unsigned mag;
            result_t r;
            mag = mag_of(w.sample);
            if (held_count < DEPTH_DEFAULT) begin
                held_samples[held_count] = w.sample;
                held_count++;
                if (mag > peak_mag)
                    peak_mag = mag;
            end
            else
                dropped = 1'b1;
            if (!w.final_req)
                return;
            for (int k = 0; k < held_count; k++) begin
                r.quantized  = code_of(held_samples[k]);
                r.max_abs    = SAMPLE_WIDTH'(peak_mag);
                r.overflowed = dropped;
                r.end_of_run = (k == held_count - 1);
                codes_due.push_back(r);
            end
            held_count = 0;
            peak_mag   = 0;
            dropped    = 1'b0;
        endtask

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_code(result_t got);
            result_t want;
            if (codes_due.size() == 0) begin
                report($sformatf("unexpected code %0d max_abs %0d", got.quantized, got.max_abs));
                return;
            end
            want = codes_due.pop_front();
            if (got.quantized !== want.quantized)
                report($sformatf("quantized %0d, want %0d", got.quantized, want.quantized));
            if (got.max_abs !== want.max_abs)
                report($sformatf("max_abs %0d, want %0d", got.max_abs, want.max_abs));
            if (got.overflowed !== want.overflowed)
                report($sformatf("overflowed %b, want %b", got.overflowed, want.overflowed));
            if (got.end_of_run !== want.end_of_run)
                report($sformatf("end_of_run %b, want %b", got.end_of_run, want.end_of_run));
        endtask
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    result_strobe;
    result_t result;

    code_scoreboard                 board;
    logic signed [SAMPLE_WIDTH-1:0] tensor_words [$];
    int unsigned                    words_sent = 0;
    int unsigned                    cycle_count = 0;

    always #(PERIOD / 2) clk = ~clk;

    absmax_int8_quantizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // every strobed code is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            board.check_code(result);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[absmax_int8_quantizer_core] ERROR");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge with start still high
    task automatic send_word(input item_t w);
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.take_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    // start low, with junk on the word lines
    task automatic idle_for(input int n);
        repeat (n)
        begin
            start <= 1'b0;
            item  <= item_t'($urandom);
            @(negedge clk);
        end
    endtask

    // sends tensor_words, the last one marked final
    task automatic send_tensor(input bit gaps);
        item_t w;
        for (int i = 0; i < tensor_words.size(); i++) begin
            if (gaps && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 9));
            w.sample    = tensor_words[i];
            w.final_req = (i == tensor_words.size() - 1);
            send_word(w);
        end
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] draw_sample(input int mode);
        int pick;
        pick = $urandom_range(0, 9);
        case (mode)
            0: return '0;
            1: return SAMPLE_WIDTH'($urandom_range(0, 600) - 300);
            default:
            begin
                if (pick == 0)
                    return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                if (pick == 1)
                    return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                if (pick == 2)
                    return '0;
                if (pick <= 4)
                    return SAMPLE_WIDTH'($urandom_range(0, 600) - 300);
                return SAMPLE_WIDTH'($urandom);
            end
        endcase
    endfunction

    initial
    begin
        int len;
        int mode;
        bit calm;

        board = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: lone zero, extremes with the most negative as peak, all zeros,
        // small values, exact full scale, unit peak
        tensor_words = '{24'sd0};
        send_tensor(1'b0);
        tensor_words = '{24'sd8388607, -24'sd8388608, 24'sd0, 24'sd1, -24'sd1, 24'sd4194304};
        send_tensor(1'b0);
        tensor_words = '{24'sd0, 24'sd0, 24'sd0};
        send_tensor(1'b0);
        tensor_words = '{-24'sd5, 24'sd5, 24'sd3, -24'sd2};
        send_tensor(1'b0);
        tensor_words = '{24'sd8388607};
        send_tensor(1'b0);
        tensor_words = '{-24'sd1};
        send_tensor(1'b0);

        // random tensors: mostly short, now and then long enough to fill and overflow
        while (words_sent < WORD_GOAL)
        begin
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(60, 72);
                1, 2, 3: len = 1;
                default: len = $urandom_range(2, 12);
            endcase
            mode = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3);
            calm = ($urandom_range(0, 3) == 0) || (words_sent + CALM_TAIL >= WORD_GOAL);
            tensor_words.delete();
            repeat (len)
                tensor_words.push_back(draw_sample(mode));
            send_tensor(!calm);
            if (!calm && $urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 9));
        end
        start <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (board.errors == 0)
            $display("[absmax_int8_quantizer_core] OK");
        else
            $display("[absmax_int8_quantizer_core] ERROR");
        $finish;
    end

endmodule
